FILE: rtl/mtsf_pkg.sv
// ----------------------------------------------------------------------------
// mtsf_pkg
// Shared constants, byte classes and controller/datapath handshake types for
// the multi-token substring filter.
// ----------------------------------------------------------------------------
package mtsf_pkg;

  localparam int MAX_TOKENS_DEF = 8;
  localparam int TOKEN_LEN_DEF  = 32;

  localparam int             LIMIT_W   = 4;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd8;
  localparam int             CNT_OUT_W = 4;

  localparam logic OP_QUERY   = 1'b0;
  localparam logic OP_NAME    = 1'b1;
  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_NAME  = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Token separators: NUL, space, tab..carriage return, dash, underscore.
  function automatic logic is_split(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]}) ||
           (c == CH_DASH) || (c == CH_UNDER);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[CH_UP_A:CH_UP_Z]}) begin
      r = c | CASE_BIT;
    end
    return r;
  endfunction

  typedef struct packed {
    logic q_open;   // take a query word
    logic q_close;  // close token / report query
    logic n_open;   // take a name word into the window
    logic n_scan;   // read one token row per cycle
    logic n_fin;    // scan complete this cycle
    logic last;     // word was marked last
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
  } dp_sts_t;

endpackage

FILE: rtl/mtsf_ram.sv
// ----------------------------------------------------------------------------
// mtsf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mtsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/mtsf_ctrl.sv
// ----------------------------------------------------------------------------
// mtsf_ctrl
// Sequencer: accepts a word, then runs the query close step or the token scan.
// ----------------------------------------------------------------------------
module mtsf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_op,
  input  logic              in_last,
  input  mtsf_pkg::dp_sts_t sts,
  output logic              busy,
  output mtsf_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_QCLOSE = 2'd1;
  localparam logic [1:0] S_NSCAN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          last_nxt  = in_last;
          state_nxt = (in_op == mtsf_pkg::OP_NAME) ? S_NSCAN : S_QCLOSE;
        end
      end
      S_QCLOSE: begin
        state_nxt = S_IDLE;
      end
      S_NSCAN: begin
        if (sts.scan_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.q_open  = accept && (in_op == mtsf_pkg::OP_QUERY);
    cmd.n_open  = accept && (in_op == mtsf_pkg::OP_NAME);
    cmd.q_close = (state_r == S_QCLOSE);
    cmd.n_scan  = (state_r == S_NSCAN);
    cmd.n_fin   = (state_r == S_NSCAN) && sts.scan_end;
    cmd.last    = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

FILE: rtl/mtsf_dp.sv
// ----------------------------------------------------------------------------
// mtsf_dp
// Datapath: token builder, token row RAM, name window, per-token compare and
// result registers.
// ----------------------------------------------------------------------------
module mtsf_dp #(
  parameter int MAX_TOKENS = mtsf_pkg::MAX_TOKENS_DEF,
  parameter int TOKEN_LEN  = mtsf_pkg::TOKEN_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mtsf_pkg::dp_cmd_t              cmd,
  output mtsf_pkg::dp_sts_t              sts,
  input  logic [7:0]                     in_char_byte,
  input  logic                           cfg_we,
  input  logic [mtsf_pkg::LIMIT_W-1:0]   cfg_wdata,
  output logic                           out_valid,
  output logic                           out_result_kind,
  output logic [mtsf_pkg::CNT_OUT_W-1:0] out_token_count,
  output logic                           out_all_found
);

  localparam int WIN_LEN = TOKEN_LEN - 1;
  localparam int LEN_W   = $clog2(TOKEN_LEN);
  localparam int CNT_W   = $clog2(MAX_TOKENS + 1);
  localparam int IDX_W   = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int ROW_W   = LEN_W + WIN_LEN * 8;
  localparam int CW      = mtsf_pkg::CNT_OUT_W;
  localparam int LW      = mtsf_pkg::LIMIT_W;

  // Control state
  logic [LW-1:0]         limit_r, limit_nxt;
  logic                  closed_r, closed_nxt;
  logic [CNT_W-1:0]      stored_r, stored_nxt;
  logic [LEN_W-1:0]      pos_r, pos_nxt;
  logic                  split_r, split_nxt;
  logic [LEN_W-1:0]      fill_r, fill_nxt;
  logic [MAX_TOKENS-1:0] found_r, found_nxt;
  logic [CNT_W-1:0]      scan_t_r, scan_t_nxt;
  logic                  rd_v_r, rd_v_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Payload
  logic [7:0]            tok_buf_r [WIN_LEN];
  logic [7:0]            tok_buf_nxt [WIN_LEN];
  logic [7:0]            win_r [WIN_LEN];
  logic [7:0]            win_nxt [WIN_LEN];
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  out_kind_r, out_kind_nxt;
  logic [CW-1:0]         out_cnt_r, out_cnt_nxt;
  logic                  out_all_r, out_all_nxt;

  // Combinational helpers
  logic [CNT_W-1:0]      eff_lim;
  logic [CNT_W-1:0]      stored_b;
  logic [LEN_W-1:0]      pos_b;
  logic                  do_close;
  logic [MAX_TOKENS-1:0] live_mask;
  logic                  hit;
  logic                  ram_we, ram_re;
  logic [ROW_W-1:0]      ram_wdata, ram_rdata;
  logic [LEN_W-1:0]      rd_len;

  mtsf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_TOKENS)
  ) u_tok_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stored_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_t_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (32'(limit_r) > 32'(MAX_TOKENS)) begin
      eff_lim = CNT_W'(MAX_TOKENS);
    end else begin
      eff_lim = CNT_W'(limit_r);
    end
  end

  // Row layout: length on top, token bytes newest-first below.
  always_comb begin
    ram_wdata[ROW_W-1 -: LEN_W] = pos_r;
    for (int k = 0; k < WIN_LEN; k++) begin
      ram_wdata[k*8 +: 8] = tok_buf_r[k];
    end
  end

  assign rd_len = ram_rdata[ROW_W-1 -: LEN_W];

  // Token bytes and window are both newest-first, so position k lines up.
  always_comb begin
    hit = (rd_len != '0) && (rd_len <= fill_r);
    for (int k = 0; k < WIN_LEN; k++) begin
      if ((LEN_W'(k) < rd_len) && (ram_rdata[k*8 +: 8] != win_r[k])) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      live_mask[i] = (CNT_W'(i) < stored_r);
    end
  end

  assign sts.scan_end = (scan_t_r == stored_r);

  always_comb begin
    limit_nxt     = limit_r;
    closed_nxt    = closed_r;
    stored_nxt    = stored_r;
    pos_nxt       = pos_r;
    split_nxt     = split_r;
    fill_nxt      = fill_r;
    found_nxt     = found_r;
    scan_t_nxt    = scan_t_r;
    rd_v_nxt      = 1'b0;
    out_valid_nxt = 1'b0;
    tok_buf_nxt   = tok_buf_r;
    win_nxt       = win_r;
    rd_idx_nxt    = rd_idx_r;
    out_kind_nxt  = out_kind_r;
    out_cnt_nxt   = out_cnt_r;
    out_all_nxt   = out_all_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    stored_b      = closed_r ? '0 : stored_r;
    pos_b         = closed_r ? '0 : pos_r;
    do_close      = (split_r || cmd.last) && (pos_r != '0) && (stored_r < eff_lim);

    if (cfg_we) begin
      limit_nxt = cfg_wdata;
    end

    // Flag the token whose row came back this cycle
    if (rd_v_r && hit) begin
      found_nxt[rd_idx_r] = 1'b1;
    end

    if (cmd.q_open) begin
      if (closed_r) begin
        stored_nxt = '0;
        pos_nxt    = '0;
        found_nxt  = '0;
      end
      closed_nxt = 1'b0;
      split_nxt  = mtsf_pkg::is_split(in_char_byte);
      if (!mtsf_pkg::is_split(in_char_byte) && (stored_b < eff_lim) &&
          (pos_b < LEN_W'(WIN_LEN))) begin
        tok_buf_nxt[0] = mtsf_pkg::to_lower(in_char_byte);
        for (int k = 1; k < WIN_LEN; k++) begin
          tok_buf_nxt[k] = tok_buf_r[k-1];
        end
        pos_nxt = pos_b + 1'b1;
      end
    end

    if (cmd.q_close) begin
      if (do_close) begin
        ram_we     = 1'b1;
        stored_nxt = stored_r + 1'b1;
        pos_nxt    = '0;
      end
      if (cmd.last) begin
        pos_nxt       = '0;
        closed_nxt    = 1'b1;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = mtsf_pkg::KIND_QUERY;
        out_cnt_nxt   = CW'(stored_nxt);
        out_all_nxt   = 1'b0;
      end
    end

    if (cmd.n_open) begin
      win_nxt[0] = in_char_byte;
      for (int k = 1; k < WIN_LEN; k++) begin
        win_nxt[k] = win_r[k-1];
      end
      if (fill_r != LEN_W'(WIN_LEN)) begin
        fill_nxt = fill_r + 1'b1;
      end
      scan_t_nxt = '0;
    end

    if (cmd.n_scan && (scan_t_r != stored_r)) begin
      ram_re     = 1'b1;
      rd_v_nxt   = 1'b1;
      rd_idx_nxt = scan_t_r[IDX_W-1:0];
      scan_t_nxt = scan_t_r + 1'b1;
    end

    if (cmd.n_fin && cmd.last) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = mtsf_pkg::KIND_NAME;
      out_cnt_nxt   = CW'(stored_r);
      out_all_nxt   = &(found_nxt | ~live_mask);
      fill_nxt      = '0;
      found_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= mtsf_pkg::LIMIT_RST;
      closed_r    <= 1'b1;
      stored_r    <= '0;
      pos_r       <= '0;
      split_r     <= 1'b0;
      fill_r      <= '0;
      found_r     <= '0;
      scan_t_r    <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      closed_r    <= closed_nxt;
      stored_r    <= stored_nxt;
      pos_r       <= pos_nxt;
      split_r     <= split_nxt;
      fill_r      <= fill_nxt;
      found_r     <= found_nxt;
      scan_t_r    <= scan_t_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_buf_r  <= tok_buf_nxt;
    win_r      <= win_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_all_r  <= out_all_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_token_count = out_cnt_r;
  assign out_all_found   = out_all_r;

endmodule

FILE: rtl/multi_token_substring_filter_core.sv
// ----------------------------------------------------------------------------
// multi_token_substring_filter_core
// Splits query text into lowercased tokens and checks that a name holds every
// stored token as a substring.
// ----------------------------------------------------------------------------
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+-----------------
//  input    | in_op, in_char_byte, in_last                  | start && !busy
//  result   | out_result_kind, out_token_count, out_all_found | out_valid strobe
//  config   | cfg_wdata (token_limit)                       | cfg_we
//
// A query word runs the query close step; a name word runs the token scan,
// in which the token RAM returns one token row per cycle for compare against
// the name window, over every stored token.
// A result is shown for one cycle on the clock after the word's last step.
// Reset is synchronous on rst_n; the token RAM holds no reset and is not swept.
// The receiver cannot stall; out_valid is a single-cycle strobe.
// ----------------------------------------------------------------------------
module multi_token_substring_filter_core #(
  parameter int MAX_TOKENS = mtsf_pkg::MAX_TOKENS_DEF,
  parameter int TOKEN_LEN  = mtsf_pkg::TOKEN_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_op,
  input  logic [7:0]                     in_char_byte,
  input  logic                           in_last,
  output logic                           out_valid,
  output logic                           out_result_kind,
  output logic [mtsf_pkg::CNT_OUT_W-1:0] out_token_count,
  output logic                           out_all_found,
  input  logic                           cfg_we,
  input  logic [mtsf_pkg::LIMIT_W-1:0]   cfg_wdata
);

  mtsf_pkg::dp_cmd_t cmd;
  mtsf_pkg::dp_sts_t sts;

  mtsf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_op   (in_op),
    .in_last (in_last),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  mtsf_dp #(
    .MAX_TOKENS (MAX_TOKENS),
    .TOKEN_LEN  (TOKEN_LEN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_char_byte    (in_char_byte),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_token_count (out_token_count),
    .out_all_found   (out_all_found)
  );

endmodule

FILE: rtl/mtsf_chk.sv
// ----------------------------------------------------------------------------
// mtsf_chk
// Port-level checks for the substring filter, bound to the top level.
// ----------------------------------------------------------------------------
module mtsf_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic                           out_result_kind,
  input logic [mtsf_pkg::CNT_OUT_W-1:0] out_token_count,
  input logic                           out_all_found
);

  // Every accepted word raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // A result appears right after the work ends
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside end of work");

  a_no_double_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on two cycles in a row");

  a_query_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == mtsf_pkg::KIND_QUERY)) |-> !out_all_found)
    else $error("query report carries a verdict");

  // With no tokens every name passes
  a_empty_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == mtsf_pkg::KIND_NAME) &&
     (out_token_count == '0)) |-> out_all_found)
    else $error("empty token store gave a failing verdict");

endmodule

bind multi_token_substring_filter_core mtsf_chk u_mtsf_chk (.*);
